// ===== rtl/core/hdr_to_sdr_tonemap_block_defines.svh =====
// ----------------------------------------------------------------------------
// hdr_to_sdr_tonemap_block_defines.svh
// Assertion macros shared by the tone-map modules. Each macro expects clk_i
// and rst_ni to be visible in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef HDR_TO_SDR_TONEMAP_BLOCK_DEFINES_SVH
`define HDR_TO_SDR_TONEMAP_BLOCK_DEFINES_SVH

// same-cycle implication
`define HSTM_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define HSTM_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/core/hstm_pkg.sv =====
// ----------------------------------------------------------------------------
// hstm_pkg
// Types and constants of the HDR to SDR tone-map pipeline.
// ----------------------------------------------------------------------------
package hstm_pkg;

  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int unsigned CODE_W        = 10;
  localparam int unsigned SDR_W         = 8;
  localparam int unsigned COEF_W        = 12;
  localparam int unsigned SCALE_W       = 10;
  localparam int unsigned PIXELS        = 4;
  localparam int unsigned CHANNELS      = 3;

  localparam int unsigned CH_R = 0;
  localparam int unsigned CH_G = 1;
  localparam int unsigned CH_B = 2;

  // delta path
  localparam int unsigned Q10_SHIFT = 10;
  localparam int unsigned PROD_W    = CODE_W + COEF_W;
  localparam int unsigned DELTA_W   = PROD_W - Q10_SHIFT;
  localparam int unsigned IDX_W     = DELTA_W + 1;
  localparam int          Q10_HALF  = 512;

  // color path
  localparam int unsigned Q8_SHIFT      = 8;
  localparam int          Q8_HALF       = 128;
  localparam int          CHROMA_OFFSET = 128;
  localparam int unsigned MIX_W         = 18;
  localparam int unsigned MIXQ_W        = MIX_W - Q8_SHIFT;
  localparam int unsigned CPROD_W       = 20;
  localparam int unsigned CHR_W         = CPROD_W - Q8_SHIFT;

  localparam int Y_R = 67;
  localparam int Y_G = 174;
  localparam int Y_B = 15;
  localparam int R709_R = 425;
  localparam int R709_G = -150;
  localparam int R709_B = -19;
  localparam int B709_R = -5;
  localparam int B709_G = -26;
  localparam int B709_B = 287;

  // APB
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned REG_IDX_W  = 3;

  typedef enum logic {
    FUNC_LOAD    = 1'b0,
    FUNC_TONEMAP = 1'b1
  } func_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RED_COEF_FROM_CR   = 3'd0,
    REG_BLUE_COEF_FROM_CB  = 3'd1,
    REG_GREEN_COEF_FROM_CB = 3'd2,
    REG_GREEN_COEF_FROM_CR = 3'd3,
    REG_CB_SCALE           = 3'd4,
    REG_CR_SCALE           = 3'd5,
    REG_CHROMA_MIN         = 3'd6,
    REG_CHROMA_MAX         = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] red_coef_from_cr;
    logic signed [COEF_W-1:0] blue_coef_from_cb;
    logic signed [COEF_W-1:0] green_coef_from_cb;
    logic signed [COEF_W-1:0] green_coef_from_cr;
    logic [SCALE_W-1:0]       cb_scale;
    logic [SCALE_W-1:0]       cr_scale;
    logic [SDR_W-1:0]         chroma_min;
    logic [SDR_W-1:0]         chroma_max;
  } cfg_t;

  typedef logic [PIXELS-1:0][CODE_W-1:0]                 luma_t;
  typedef logic [PIXELS-1:0][CHANNELS-1:0][ADDR_W-1:0]   px_idx_t;
  typedef logic [PIXELS-1:0][CHANNELS-1:0][SDR_W-1:0]    px_val_t;

  typedef struct packed {
    func_e             func;
    logic [ADDR_W-1:0] table_index;
    logic [SDR_W-1:0]  table_value;
    logic [CODE_W-1:0] cb_code;
    logic [CODE_W-1:0] cr_code;
    luma_t             luma;
  } item_t;

  typedef struct packed {
    func_e             func;
    logic [ADDR_W-1:0] table_index;
    logic [SDR_W-1:0]  table_value;
    px_idx_t           px;
  } idx_item_t;

  typedef struct packed {
    logic [PIXELS-1:0][SDR_W-1:0] sdr;
    logic [SDR_W-1:0]             cb;
    logic [SDR_W-1:0]             cr;
  } result_t;

endpackage

// ===== rtl/core/hstm_in_if.sv =====
// ----------------------------------------------------------------------------
// hstm_in_if
// Input channel of the tone-map block: table loads and 2x2 blocks.
// ----------------------------------------------------------------------------
interface hstm_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [hstm_pkg::ADDR_W-1:0]  table_index;
  logic [hstm_pkg::SDR_W-1:0]   table_value;
  logic [hstm_pkg::CODE_W-1:0]  cb_code;
  logic [hstm_pkg::CODE_W-1:0]  cr_code;
  logic [hstm_pkg::CODE_W-1:0]  luma_top_left;
  logic [hstm_pkg::CODE_W-1:0]  luma_top_right;
  logic [hstm_pkg::CODE_W-1:0]  luma_bottom_left;
  logic [hstm_pkg::CODE_W-1:0]  luma_bottom_right;

  modport source (
    output valid, func, table_index, table_value, cb_code, cr_code,
           luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
    input  ready
  );

  modport sink (
    input  valid, func, table_index, table_value, cb_code, cr_code,
           luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
    output ready
  );
endinterface

// ===== rtl/core/hstm_out_if.sv =====
// ----------------------------------------------------------------------------
// hstm_out_if
// Output channel of the tone-map block: four SDR luma codes and chroma.
// ----------------------------------------------------------------------------
interface hstm_out_if;
  logic                        valid;
  logic                        ready;
  logic [hstm_pkg::SDR_W-1:0]  sdr_top_left;
  logic [hstm_pkg::SDR_W-1:0]  sdr_top_right;
  logic [hstm_pkg::SDR_W-1:0]  sdr_bottom_left;
  logic [hstm_pkg::SDR_W-1:0]  sdr_bottom_right;
  logic [hstm_pkg::SDR_W-1:0]  cb_result;
  logic [hstm_pkg::SDR_W-1:0]  cr_result;

  modport source (
    output valid, sdr_top_left, sdr_top_right, sdr_bottom_left, sdr_bottom_right,
           cb_result, cr_result,
    input  ready
  );

  modport sink (
    input  valid, sdr_top_left, sdr_top_right, sdr_bottom_left, sdr_bottom_right,
           cb_result, cr_result,
    output ready
  );
endinterface

// ===== rtl/core/hstm_ram.sv =====
// ----------------------------------------------------------------------------
// hstm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hstm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/hstm_index.sv =====
// ----------------------------------------------------------------------------
// hstm_index
// Stages 1-2: Q10 chroma deltas, then per-pixel, per-channel table indexes.
// ----------------------------------------------------------------------------
module hstm_index (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hstm_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hstm_pkg::item_t     in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hstm_pkg::idx_item_t out_item_o
);

  // centered code times coefficient, rounded to Q0
  function automatic logic signed [hstm_pkg::DELTA_W-1:0] q10_delta(
    input logic [hstm_pkg::CODE_W-1:0]        code,
    input logic signed [hstm_pkg::COEF_W-1:0] coef
  );
    logic signed [hstm_pkg::PROD_W-1:0] x_e;
    logic signed [hstm_pkg::PROD_W-1:0] c_e;
    logic signed [hstm_pkg::PROD_W-1:0] p;
    // code - 512 is the code with its top bit inverted
    x_e = hstm_pkg::PROD_W'($signed({~code[hstm_pkg::CODE_W-1],
                                     code[hstm_pkg::CODE_W-2:0]}));
    c_e = hstm_pkg::PROD_W'(coef);
    p   = x_e * c_e + hstm_pkg::PROD_W'(hstm_pkg::Q10_HALF);
    return p[hstm_pkg::PROD_W-1:hstm_pkg::Q10_SHIFT];
  endfunction

  function automatic logic [hstm_pkg::ADDR_W-1:0] clamp_idx(
    input logic signed [hstm_pkg::IDX_W-1:0] v
  );
    logic [hstm_pkg::ADDR_W-1:0] r;
    if (v[hstm_pkg::IDX_W-1]) begin
      r = '0;
    end else if (|v[hstm_pkg::IDX_W-2:hstm_pkg::ADDR_W]) begin
      r = '1;
    end else begin
      r = v[hstm_pkg::ADDR_W-1:0];
    end
    return r;
  endfunction

  logic en1, en2;
  logic v1_q, v2_q;

  hstm_pkg::func_e                    func1_q;
  logic [hstm_pkg::ADDR_W-1:0]        tidx1_q;
  logic [hstm_pkg::SDR_W-1:0]         tval1_q;
  hstm_pkg::luma_t                    luma1_q;
  logic signed [hstm_pkg::DELTA_W-1:0] dr1_q, db1_q, dgr1_q, dgb1_q;

  logic signed [hstm_pkg::IDX_W-1:0]  dr_e, db_e, dg_e;
  hstm_pkg::idx_item_t                item2_d, item2_q;

  assign en2        = !v2_q || out_ready_i;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  // stage 1: four multiplies
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      func1_q <= in_item_i.func;
      tidx1_q <= in_item_i.table_index;
      tval1_q <= in_item_i.table_value;
      luma1_q <= in_item_i.luma;
      dr1_q   <= q10_delta(in_item_i.cr_code, cfg_i.red_coef_from_cr);
      db1_q   <= q10_delta(in_item_i.cb_code, cfg_i.blue_coef_from_cb);
      dgr1_q  <= q10_delta(in_item_i.cr_code, cfg_i.green_coef_from_cr);
      dgb1_q  <= q10_delta(in_item_i.cb_code, cfg_i.green_coef_from_cb);
    end
  end

  // stage 2: luma plus delta, clamped into the table
  assign dr_e = hstm_pkg::IDX_W'(dr1_q);
  assign db_e = hstm_pkg::IDX_W'(db1_q);
  assign dg_e = hstm_pkg::IDX_W'(dgr1_q) + hstm_pkg::IDX_W'(dgb1_q);

  always_comb begin
    item2_d.func        = func1_q;
    item2_d.table_index = tidx1_q;
    item2_d.table_value = tval1_q;
    for (int p = 0; p < hstm_pkg::PIXELS; p++) begin
      item2_d.px[p][hstm_pkg::CH_R] =
        clamp_idx(hstm_pkg::IDX_W'($signed({1'b0, luma1_q[p]})) + dr_e);
      item2_d.px[p][hstm_pkg::CH_G] =
        clamp_idx(hstm_pkg::IDX_W'($signed({1'b0, luma1_q[p]})) + dg_e);
      item2_d.px[p][hstm_pkg::CH_B] =
        clamp_idx(hstm_pkg::IDX_W'($signed({1'b0, luma1_q[p]})) + db_e);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      item2_q <= item2_d;
    end
  end

  assign out_valid_o = v2_q;
  assign out_item_o  = item2_q;

endmodule

// ===== rtl/core/hstm_lookup.sv =====
// ----------------------------------------------------------------------------
// hstm_lookup
// Stage 3: twelve copies of the transfer table, one per pixel and channel.
// Loads write every copy as they leave stage 2; tone-map items read here.
// ----------------------------------------------------------------------------
`include "hdr_to_sdr_tonemap_block_defines.svh"

module hstm_lookup (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hstm_pkg::idx_item_t in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hstm_pkg::px_val_t   out_px_o
);

  logic              en3;
  logic              ram_we;
  logic              v3_q;
  hstm_pkg::px_val_t rd_data;

  assign en3        = !v3_q || out_ready_i;
  assign in_ready_o = en3;
  assign ram_we     = in_valid_i && en3 && (in_item_i.func == hstm_pkg::FUNC_LOAD);

  // loads stop here: only tone-map items go on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= in_valid_i && (in_item_i.func == hstm_pkg::FUNC_TONEMAP);
    end
  end

  for (genvar gp = 0; gp < hstm_pkg::PIXELS; gp++) begin : g_pix
    for (genvar gc = 0; gc < hstm_pkg::CHANNELS; gc++) begin : g_chan
      hstm_ram #(
        .Width (hstm_pkg::SDR_W),
        .Depth (hstm_pkg::TABLE_ENTRIES)
      ) u_ram (
        .clk_i   (clk_i),
        .we_i    (ram_we),
        .waddr_i (in_item_i.table_index),
        .wdata_i (in_item_i.table_value),
        .re_i    (en3),
        .raddr_i (in_item_i.px[gp][gc]),
        .rdata_o (rd_data[gp][gc])
      );
    end
  end

  assign out_valid_o = v3_q;
  assign out_px_o    = rd_data;

  `HSTM_ASSERT_NXT(a_load_gives_no_item, ram_we, !v3_q, "load item reached the color stages")
  `HSTM_ASSERT_NXT(a_stall_holds_lookup, v3_q && !out_ready_i, v3_q && $stable(rd_data),
                   "stalled lookup data changed")

endmodule

// ===== rtl/core/hstm_color.sv =====
// ----------------------------------------------------------------------------
// hstm_color
// Stages 4-6: SDR luma of each pixel, gamut matrix and chroma scaling of
// the top-left pixel, final chroma limits. Stage 6 is the output register.
// ----------------------------------------------------------------------------
`include "hdr_to_sdr_tonemap_block_defines.svh"

module hstm_color (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hstm_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hstm_pkg::px_val_t in_px_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hstm_pkg::result_t out_res_o
);

  // kr*r + kg*g + kb*b + 128
  function automatic logic signed [hstm_pkg::MIX_W-1:0] mix3(
    input logic [hstm_pkg::SDR_W-1:0] r,
    input logic [hstm_pkg::SDR_W-1:0] g,
    input logic [hstm_pkg::SDR_W-1:0] b,
    input int                         kr,
    input int                         kg,
    input int                         kb
  );
    logic signed [hstm_pkg::MIX_W-1:0] re, ge, be;
    re = hstm_pkg::MIX_W'($signed({1'b0, r}));
    ge = hstm_pkg::MIX_W'($signed({1'b0, g}));
    be = hstm_pkg::MIX_W'($signed({1'b0, b}));
    return re * hstm_pkg::MIX_W'(kr) + ge * hstm_pkg::MIX_W'(kg) +
           be * hstm_pkg::MIX_W'(kb) + hstm_pkg::MIX_W'(hstm_pkg::Q8_HALF);
  endfunction

  function automatic logic [hstm_pkg::SDR_W-1:0] clamp8(
    input logic signed [hstm_pkg::MIXQ_W-1:0] v
  );
    logic [hstm_pkg::SDR_W-1:0] r;
    if (v[hstm_pkg::MIXQ_W-1]) begin
      r = '0;
    end else if (|v[hstm_pkg::MIXQ_W-2:hstm_pkg::SDR_W]) begin
      r = '1;
    end else begin
      r = v[hstm_pkg::SDR_W-1:0];
    end
    return r;
  endfunction

  // round, recenter, then min first and max last so crossed limits give max
  function automatic logic [hstm_pkg::SDR_W-1:0] chroma_out(
    input logic signed [hstm_pkg::CPROD_W-1:0] p,
    input logic [hstm_pkg::SDR_W-1:0]          lo,
    input logic [hstm_pkg::SDR_W-1:0]          hi
  );
    logic signed [hstm_pkg::CPROD_W-1:0] t;
    logic signed [hstm_pkg::CHR_W-1:0]   v, lo_e, hi_e;
    t    = p + hstm_pkg::CPROD_W'(hstm_pkg::Q8_HALF);
    v    = t[hstm_pkg::CPROD_W-1:hstm_pkg::Q8_SHIFT] +
           hstm_pkg::CHR_W'(hstm_pkg::CHROMA_OFFSET);
    lo_e = hstm_pkg::CHR_W'({1'b0, lo});
    hi_e = hstm_pkg::CHR_W'({1'b0, hi});
    if (v < lo_e) begin
      v = lo_e;
    end
    if (v > hi_e) begin
      v = hi_e;
    end
    return v[hstm_pkg::SDR_W-1:0];
  endfunction

  logic en4, en5, en6;
  logic v4_q, v5_q, v6_q;

  // stage 4
  logic signed [hstm_pkg::MIX_W-1:0]       y_sum [hstm_pkg::PIXELS];
  logic signed [hstm_pkg::MIX_W-1:0]       r709_sum, b709_sum;
  logic [hstm_pkg::PIXELS-1:0][hstm_pkg::SDR_W-1:0] y4_d, y4_q, y5_q;
  logic signed [hstm_pkg::MIXQ_W-1:0]      r709_q, b709_q;

  // stage 5
  logic [hstm_pkg::SDR_W-1:0]              r709_c, b709_c;
  logic signed [hstm_pkg::SDR_W:0]         dcb, dcr;
  logic signed [hstm_pkg::CPROD_W-1:0]     cb_prod_d, cr_prod_d, cb_prod_q, cr_prod_q;

  // stage 6
  hstm_pkg::result_t                       res_d, res_q;

  assign en6        = !v6_q || out_ready_i;
  assign en5        = !v5_q || en6;
  assign en4        = !v4_q || en5;
  assign in_ready_o = en4;

  always_comb begin
    for (int p = 0; p < hstm_pkg::PIXELS; p++) begin
      y_sum[p] = mix3(in_px_i[p][hstm_pkg::CH_R], in_px_i[p][hstm_pkg::CH_G],
                      in_px_i[p][hstm_pkg::CH_B],
                      hstm_pkg::Y_R, hstm_pkg::Y_G, hstm_pkg::Y_B);
      y4_d[p]  = y_sum[p][hstm_pkg::SDR_W+hstm_pkg::Q8_SHIFT-1:hstm_pkg::Q8_SHIFT];
    end
  end

  assign r709_sum = mix3(in_px_i[0][hstm_pkg::CH_R], in_px_i[0][hstm_pkg::CH_G],
                         in_px_i[0][hstm_pkg::CH_B],
                         hstm_pkg::R709_R, hstm_pkg::R709_G, hstm_pkg::R709_B);
  assign b709_sum = mix3(in_px_i[0][hstm_pkg::CH_R], in_px_i[0][hstm_pkg::CH_G],
                         in_px_i[0][hstm_pkg::CH_B],
                         hstm_pkg::B709_R, hstm_pkg::B709_G, hstm_pkg::B709_B);

  always_ff @(posedge clk_i) begin
    if (en4) begin
      y4_q   <= y4_d;
      r709_q <= r709_sum[hstm_pkg::MIX_W-1:hstm_pkg::Q8_SHIFT];
      b709_q <= b709_sum[hstm_pkg::MIX_W-1:hstm_pkg::Q8_SHIFT];
    end
  end

  // stage 5: (709 value - y) * scale
  assign r709_c    = clamp8(r709_q);
  assign b709_c    = clamp8(b709_q);
  assign dcb       = $signed({1'b0, b709_c}) - $signed({1'b0, y4_q[0]});
  assign dcr       = $signed({1'b0, r709_c}) - $signed({1'b0, y4_q[0]});
  assign cb_prod_d = hstm_pkg::CPROD_W'(dcb) *
                     hstm_pkg::CPROD_W'($signed({1'b0, cfg_i.cb_scale}));
  assign cr_prod_d = hstm_pkg::CPROD_W'(dcr) *
                     hstm_pkg::CPROD_W'($signed({1'b0, cfg_i.cr_scale}));

  always_ff @(posedge clk_i) begin
    if (en5) begin
      y5_q      <= y4_q;
      cb_prod_q <= cb_prod_d;
      cr_prod_q <= cr_prod_d;
    end
  end

  // stage 6
  always_comb begin
    res_d.sdr = y5_q;
    res_d.cb  = chroma_out(cb_prod_q, cfg_i.chroma_min, cfg_i.chroma_max);
    res_d.cr  = chroma_out(cr_prod_q, cfg_i.chroma_min, cfg_i.chroma_max);
  end

  always_ff @(posedge clk_i) begin
    if (en6) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en4) begin
        v4_q <= in_valid_i;
      end
      if (en5) begin
        v5_q <= v4_q;
      end
      if (en6) begin
        v6_q <= v5_q;
      end
    end
  end

  assign out_valid_o = v6_q;
  assign out_res_o   = res_q;

  `HSTM_ASSERT_NXT(a_s4_capture, in_valid_i && in_ready_o, v4_q, "stage 4 dropped a transfer")
  `HSTM_ASSERT_IMP(a_out_from_s5, $rose(v6_q), $past(v5_q), "result appeared without stage 5")

endmodule

// ===== rtl/core/hdr_to_sdr_tonemap_block.sv =====
// ----------------------------------------------------------------------------
// hdr_to_sdr_tonemap_block
// Tone-maps 2x2 blocks of 10-bit 4:2:0 HDR video into 8-bit SDR.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  - valid/ready channel. func 0 loads one byte of the 1024-entry
//           transfer table; func 1 carries a 2x2 block (Cb, Cr, four luma).
//   out_o - valid/ready channel, one result per 2x2 block, none per load.
//   APB   - eight config registers at byte address 4*i; write them only while
//           no block is in flight. pready is tied high, reads return values.
// Timing:
//   Six register stages: delta multiply, index clamp, table read, luma and
//   gamut matrix, chroma scale, output register. While out_o does not stall,
//   one item is taken every cycle. The table read stage sets the rate: each
//   pixel and channel has its own table copy, so all twelve reads happen in
//   the same cycle, and a load writes all copies at once.
// Reset clears the valid bits and sets the registers to their defaults; the
// table is undefined until loaded, so load every entry a block can touch.
// When out_o stalls, stages fill one by one and in_i.ready drops once all
// are full; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module hdr_to_sdr_tonemap_block (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  hstm_in_if.sink                             in_i,
  hstm_out_if.source                          out_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hstm_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [hstm_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [hstm_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  hstm_pkg::cfg_t      cfg_q;
  hstm_pkg::reg_idx_e  reg_idx;
  logic                cfg_we;

  hstm_pkg::item_t     item;
  hstm_pkg::idx_item_t idx_item;
  hstm_pkg::px_val_t   px_val;
  hstm_pkg::result_t   res;

  logic idx_valid, idx_ready;
  logic lut_valid, lut_ready;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = hstm_pkg::reg_idx_e'(paddr[hstm_pkg::CFG_ADDR_W-1:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.red_coef_from_cr   <= '0;
      cfg_q.blue_coef_from_cb  <= '0;
      cfg_q.green_coef_from_cb <= '0;
      cfg_q.green_coef_from_cr <= '0;
      cfg_q.cb_scale           <= hstm_pkg::SCALE_W'(256);
      cfg_q.cr_scale           <= hstm_pkg::SCALE_W'(256);
      cfg_q.chroma_min         <= '0;
      cfg_q.chroma_max         <= '1;
    end else if (cfg_we) begin
      unique case (reg_idx)
        hstm_pkg::REG_RED_COEF_FROM_CR:
          cfg_q.red_coef_from_cr   <= pwdata[hstm_pkg::COEF_W-1:0];
        hstm_pkg::REG_BLUE_COEF_FROM_CB:
          cfg_q.blue_coef_from_cb  <= pwdata[hstm_pkg::COEF_W-1:0];
        hstm_pkg::REG_GREEN_COEF_FROM_CB:
          cfg_q.green_coef_from_cb <= pwdata[hstm_pkg::COEF_W-1:0];
        hstm_pkg::REG_GREEN_COEF_FROM_CR:
          cfg_q.green_coef_from_cr <= pwdata[hstm_pkg::COEF_W-1:0];
        hstm_pkg::REG_CB_SCALE:   cfg_q.cb_scale   <= pwdata[hstm_pkg::SCALE_W-1:0];
        hstm_pkg::REG_CR_SCALE:   cfg_q.cr_scale   <= pwdata[hstm_pkg::SCALE_W-1:0];
        hstm_pkg::REG_CHROMA_MIN: cfg_q.chroma_min <= pwdata[hstm_pkg::SDR_W-1:0];
        hstm_pkg::REG_CHROMA_MAX: cfg_q.chroma_max <= pwdata[hstm_pkg::SDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      hstm_pkg::REG_RED_COEF_FROM_CR:
        prdata = hstm_pkg::CFG_DATA_W'(cfg_q.red_coef_from_cr);
      hstm_pkg::REG_BLUE_COEF_FROM_CB:
        prdata = hstm_pkg::CFG_DATA_W'(cfg_q.blue_coef_from_cb);
      hstm_pkg::REG_GREEN_COEF_FROM_CB:
        prdata = hstm_pkg::CFG_DATA_W'(cfg_q.green_coef_from_cb);
      hstm_pkg::REG_GREEN_COEF_FROM_CR:
        prdata = hstm_pkg::CFG_DATA_W'(cfg_q.green_coef_from_cr);
      hstm_pkg::REG_CB_SCALE:   prdata = hstm_pkg::CFG_DATA_W'(cfg_q.cb_scale);
      hstm_pkg::REG_CR_SCALE:   prdata = hstm_pkg::CFG_DATA_W'(cfg_q.cr_scale);
      hstm_pkg::REG_CHROMA_MIN: prdata = hstm_pkg::CFG_DATA_W'(cfg_q.chroma_min);
      hstm_pkg::REG_CHROMA_MAX: prdata = hstm_pkg::CFG_DATA_W'(cfg_q.chroma_max);
      default: ;
    endcase
  end

  // input payload
  always_comb begin
    item.func        = hstm_pkg::func_e'(in_i.func);
    item.table_index = in_i.table_index;
    item.table_value = in_i.table_value;
    item.cb_code     = in_i.cb_code;
    item.cr_code     = in_i.cr_code;
    item.luma[0]     = in_i.luma_top_left;
    item.luma[1]     = in_i.luma_top_right;
    item.luma[2]     = in_i.luma_bottom_left;
    item.luma[3]     = in_i.luma_bottom_right;
  end

  hstm_index u_index (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_item_i   (item),
    .out_valid_o (idx_valid),
    .out_ready_i (idx_ready),
    .out_item_o  (idx_item)
  );

  hstm_lookup u_lookup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (idx_valid),
    .in_ready_o  (idx_ready),
    .in_item_i   (idx_item),
    .out_valid_o (lut_valid),
    .out_ready_i (lut_ready),
    .out_px_o    (px_val)
  );

  hstm_color u_color (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (lut_valid),
    .in_ready_o  (lut_ready),
    .in_px_i     (px_val),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_res_o   (res)
  );

  assign out_o.sdr_top_left     = res.sdr[0];
  assign out_o.sdr_top_right    = res.sdr[1];
  assign out_o.sdr_bottom_left  = res.sdr[2];
  assign out_o.sdr_bottom_right = res.sdr[3];
  assign out_o.cb_result        = res.cb;
  assign out_o.cr_result        = res.cr;

endmodule
